/* sv/lpc_pkg.sv */
// lpc_pkg: shared types, status codes and default sizes for the LRU page cache tag store.
// No dependencies.
`timescale 1ns / 1ps

package lpc_pkg;

	localparam int ENTRIES_DEF   = 16;
	localparam int KEY_BITS_DEF  = 32;
	localparam int TIME_BITS_DEF = 32;

	localparam int STATUS_BITS = 2;
	localparam int SLOT_BITS   = 4;
	localparam int EVICT_BITS  = 32;
	localparam int WIDE_BITS   = 64;

	localparam logic [STATUS_BITS-1:0] STATUS_HIT     = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_FILL    = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_REPLACE = 2'd2;
	localparam logic [STATUS_BITS-1:0] STATUS_MISS    = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

/* sv/lpc_ram.sv */
// lpc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/lru_page_cache_tags.sv */
// lru_page_cache_tags: fully associative tag store with timestamp LRU replacement.
// Depends on lpc_pkg and lpc_ram.
// A request is taken in ST_IDLE; ST_SCAN reads the n entries in use (n = 1..ENTRIES), none when
// the store is empty; ST_FINISH waits while the previous result is stalled, then writes the result.
// No new request is taken until ST_FINISH has passed; a single pass over the
// tag RAM read port does the key match and the oldest-stamp search, one entry per cycle.
// A new request is taken while the previous result waits in the output register.
// Reset clears the fill count and control; RAM contents are undefined but never read
// at or above the fill count.
`timescale 1ns / 1ps

module lru_page_cache_tags #(
	parameter int ENTRIES   = lpc_pkg::ENTRIES_DEF,
	parameter int KEY_BITS  = lpc_pkg::KEY_BITS_DEF,
	parameter int TIME_BITS = lpc_pkg::TIME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [KEY_BITS-1:0]                 key,
	input  logic [TIME_BITS-1:0]                now,
	input  logic                                loadable,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [lpc_pkg::STATUS_BITS-1:0]     status,
	output logic [lpc_pkg::SLOT_BITS-1:0]       slot,
	output logic [lpc_pkg::EVICT_BITS-1:0]      evicted_key
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int DW = KEY_BITS + TIME_BITS;
	localparam int AC = (AW > CW) ? AW : CW;
	localparam int SW = (AC > lpc_pkg::SLOT_BITS) ? AC : lpc_pkg::SLOT_BITS;

	lpc_pkg::state_t state_q, state_d;

	logic [CW-1:0]        fill_q;
	logic [CW-1:0]        idx_q;
	logic                 rd_valid_s1;
	logic [AW-1:0]        addr_s1;
	logic [KEY_BITS-1:0]  key_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 ld_q;
	logic                 hit_q;
	logic [AW-1:0]        hit_slot_q;
	logic [TIME_BITS-1:0] best_stamp_q;
	logic [AW-1:0]        victim_q;
	logic [KEY_BITS-1:0]  best_key_q;

	logic                            rsp_valid_q;
	logic [lpc_pkg::STATUS_BITS-1:0] status_q;
	logic [lpc_pkg::SLOT_BITS-1:0]   slot_q;
	logic [lpc_pkg::EVICT_BITS-1:0]  evicted_q;

	logic                 issue;
	logic                 finish;
	logic                 full;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [DW-1:0]        rd_data;
	logic [KEY_BITS-1:0]  rd_key;
	logic [TIME_BITS-1:0] rd_stamp;

	logic [lpc_pkg::STATUS_BITS-1:0] status_d;
	logic [SW-1:0]                   slot_wide;
	logic [lpc_pkg::WIDE_BITS-1:0]   evict_wide;

	assign rd_key   = rd_data[DW-1:TIME_BITS];
	assign rd_stamp = rd_data[TIME_BITS-1:0];
	assign full     = (fill_q == CW'(ENTRIES));

	lpc_ram #(
		.WIDTH(DW),
		.DEPTH(ENTRIES)
	) u_tags (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata ({key_q, now_q}),
		.re    (issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		issue     = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			lpc_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = lpc_pkg::ST_SCAN;
				end
			end
			lpc_pkg::ST_SCAN: begin
				issue = (idx_q < fill_q);
				if (!issue && !rd_valid_s1) begin
					state_d = lpc_pkg::ST_FINISH;
				end
			end
			lpc_pkg::ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					finish  = 1'b1;
					state_d = lpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpc_pkg::ST_IDLE;
			end
		endcase
	end

	// outcome of the finished scan
	always_comb begin
		wr_en      = finish && (hit_q || ld_q);
		wr_addr    = fill_q[AW-1:0];
		status_d   = lpc_pkg::STATUS_FILL;
		slot_wide  = SW'(fill_q);
		evict_wide = '0;
		if (hit_q) begin
			wr_addr   = hit_slot_q;
			status_d  = lpc_pkg::STATUS_HIT;
			slot_wide = SW'(hit_slot_q);
		end else if (!ld_q) begin
			status_d  = lpc_pkg::STATUS_MISS;
			slot_wide = '0;
		end else if (full) begin
			wr_addr    = victim_q;
			status_d   = lpc_pkg::STATUS_REPLACE;
			slot_wide  = SW'(victim_q);
			evict_wide = lpc_pkg::WIDE_BITS'(best_key_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (finish && !hit_q && ld_q && !full) begin
				fill_q <= fill_q + CW'(1);
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lpc_pkg::ST_IDLE && req_valid) begin
			key_q <= key;
			now_q <= now;
			ld_q  <= loadable;
			hit_q <= 1'b0;
			idx_q <= '0;
		end
		if (issue) begin
			idx_q   <= idx_q + CW'(1);
			addr_s1 <= idx_q[AW-1:0];
		end
		if (rd_valid_s1) begin
			if (!hit_q && rd_key == key_q) begin
				hit_q      <= 1'b1;
				hit_slot_q <= addr_s1;
			end
			if (addr_s1 == '0 || rd_stamp < best_stamp_q) begin
				best_stamp_q <= rd_stamp;
				victim_q     <= addr_s1;
				best_key_q   <= rd_key;
			end
		end
		if (finish) begin
			status_q  <= status_d;
			slot_q    <= slot_wide[lpc_pkg::SLOT_BITS-1:0];
			evicted_q <= evict_wide[lpc_pkg::EVICT_BITS-1:0];
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign evicted_key = evicted_q;

endmodule

/* verif/lru_page_cache_tags_test.sv */
// lru_page_cache_tags_test: self-checking bench for the LRU page cache tag store.
// Queue-fed driver, response monitor and a local tag store predictor; needs lpc_pkg.
`timescale 1ns / 1ps

module lru_page_cache_tags_test;

	localparam int TAG_ENTRIES = lpc_pkg::ENTRIES_DEF;
	localparam int IDLE_LIMIT  = 1000;
	localparam int POOL_SIZE   = 24;

	typedef struct {
		logic [lpc_pkg::KEY_BITS_DEF-1:0]  key;
		logic [lpc_pkg::TIME_BITS_DEF-1:0] now;
		logic                              loadable;
		bit                                drain;
	} page_req_t;

	typedef struct {
		logic [lpc_pkg::STATUS_BITS-1:0] status;
		logic [lpc_pkg::SLOT_BITS-1:0]   slot;
		logic [lpc_pkg::EVICT_BITS-1:0]  evicted_key;
	} lookup_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [lpc_pkg::KEY_BITS_DEF-1:0] key = '0;
	logic [lpc_pkg::TIME_BITS_DEF-1:0] now = '0;
	logic loadable = 1'b0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [lpc_pkg::STATUS_BITS-1:0] status;
	logic [lpc_pkg::SLOT_BITS-1:0] slot;
	logic [lpc_pkg::EVICT_BITS-1:0] evicted_key;

	page_req_t pending_requests[$];
	lookup_result_t expected_results[$];

	logic [lpc_pkg::KEY_BITS_DEF-1:0] tag_keys[TAG_ENTRIES];
	logic [lpc_pkg::TIME_BITS_DEF-1:0] tag_stamps[TAG_ENTRIES];
	int tag_count = 0;

	int requests_sent = 0;
	int results_seen = 0;
	int errors = 0;
	int idle_cycles = 0;
	int src_wait = 0;
	int sink_wait = 0;

	lru_page_cache_tags i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.key         (key),
		.now         (now),
		.loadable    (loadable),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.slot        (slot),
		.evicted_key (evicted_key)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// stretches of back-to-back traffic every 256 transfers
	function automatic int draw_wait(input int count);
		if (count % 256 < 48)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	function automatic lookup_result_t lookup_page(
			input logic [lpc_pkg::KEY_BITS_DEF-1:0] k,
			input logic [lpc_pkg::TIME_BITS_DEF-1:0] t, input logic ld);
		lookup_result_t r;
		bit found;
		int victim;
		r.status = lpc_pkg::STATUS_MISS;
		r.slot = '0;
		r.evicted_key = '0;
		found = 0;
		victim = 0;
		for (int i = 0; i < tag_count; i++) begin
			if (!found && tag_keys[i] == k) begin
				found = 1;
				tag_stamps[i] = t;
				r.status = lpc_pkg::STATUS_HIT;
				r.slot = lpc_pkg::SLOT_BITS'(i);
			end
		end
		if (!found && ld) begin
			if (tag_count < TAG_ENTRIES) begin
				tag_keys[tag_count] = k;
				tag_stamps[tag_count] = t;
				r.status = lpc_pkg::STATUS_FILL;
				r.slot = lpc_pkg::SLOT_BITS'(tag_count);
				tag_count++;
			end else begin
				for (int i = 1; i < TAG_ENTRIES; i++) begin
					if (tag_stamps[i] < tag_stamps[victim])
						victim = i;
				end
				r.status = lpc_pkg::STATUS_REPLACE;
				r.slot = lpc_pkg::SLOT_BITS'(victim);
				r.evicted_key = tag_keys[victim];
				tag_keys[victim] = k;
				tag_stamps[victim] = t;
			end
		end
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		logic sent;
		logic load;
		page_req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			key <= '0;
			now <= '0;
			loadable <= 1'b0;
			src_wait <= 0;
		end else begin
			sent = req_valid && !req_stall;
			load = 1'b0;
			if (sent) begin
				expected_results.push_back(lookup_page(key, now, loadable));
				requests_sent++;
			end
			if (!req_valid || sent) begin
				if (src_wait > 0) begin
					src_wait <= src_wait - 1;
				end else if (pending_requests.size() > 0 && pending_requests[0].drain) begin
					if (expected_results.size() == 0)
						void'(pending_requests.pop_front());
				end else if (pending_requests.size() > 0) begin
					nxt = pending_requests.pop_front();
					load = 1'b1;
					key <= nxt.key;
					now <= nxt.now;
					loadable <= nxt.loadable;
					src_wait <= draw_wait(requests_sent);
				end
				req_valid <= load;
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		int w;
		lookup_result_t exp_r;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			sink_wait <= 0;
		end else begin
			w = sink_wait;
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result status %0d slot %0d evicted %h",
						$time, status, slot, evicted_key);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (status !== exp_r.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_r.status, status);
						errors++;
					end
					if (slot !== exp_r.slot) begin
						$display("%0t: slot expected %0d actual %0d",
							$time, exp_r.slot, slot);
						errors++;
					end
					if (evicted_key !== exp_r.evicted_key) begin
						$display("%0t: evicted_key expected %h actual %h",
							$time, exp_r.evicted_key, evicted_key);
						errors++;
					end
				end
				w = draw_wait(results_seen);
			end else if (rsp_valid && w > 0) begin
				w--;
			end
			sink_wait <= w;
			rsp_stall <= (w > 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("lru_page_cache_tags test failed");
				$finish;
			end
		end
	end

	task automatic push_req(input logic [31:0] k, input logic [31:0] t, input logic ld);
		page_req_t p;
		p.key = k;
		p.now = t;
		p.loadable = ld;
		p.drain = 0;
		pending_requests.push_back(p);
	endtask

	task automatic push_drain();
		page_req_t p;
		p.key = '0;
		p.now = '0;
		p.loadable = 1'b0;
		p.drain = 1;
		pending_requests.push_back(p);
	endtask

	initial begin
		logic [31:0] key_pool[POOL_SIZE];
		logic [31:0] clock_now;
		logic [31:0] k;
		logic [31:0] t;
		// directed: empty miss, fills with extremes and tied stamps, hits, replacements
		push_req(32'h0, 32'h0, 1'b0);
		push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		push_req(32'h0, 32'h0, 1'b1);
		for (int i = 2; i < TAG_ENTRIES; i++)
			push_req(32'h1000 + i, 32'd100, 1'b1);
		push_req(32'h5555_AAAA, 32'd150, 1'b0);
		push_req(32'hAAAA_5555, 32'd200, 1'b1);
		push_req(32'h1234_5678, 32'd201, 1'b1);
		push_req(32'hFFFF_FFFF, 32'h0, 1'b1);
		push_req(32'h8765_4321, 32'd202, 1'b1);
		push_req(32'h1234_5678, 32'd203, 1'b0);
		push_req(32'h1003, 32'hFFFF_FFFE, 1'b0);
		push_drain();

		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		clock_now = 32'd1000;
		for (int n = 0; n < 1500; n++) begin
			if (n % 400 == 399)
				push_drain();
			if ($urandom_range(0, 9) == 0)
				key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
			if ($urandom_range(0, 9) < 7)
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				k = $urandom;
			clock_now = clock_now + $urandom_range(0, 3);
			t = ($urandom_range(0, 19) == 0) ? $urandom : clock_now;
			push_req(k, t, ($urandom_range(0, 4) != 0));
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_requests.size() > 0 || req_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("lru_page_cache_tags test passed");
		else
			$display("lru_page_cache_tags test failed");
		$finish;
	end

endmodule
